### design/nam_pkg.sv
`default_nettype none

package nam_pkg;

    // Fixed field widths of the result word
    localparam int INDEX_BITS  = 6;
    localparam int DIST_BITS   = 25;
    localparam int FARE_BITS   = 33;
    localparam int STATUS_BITS = 2;
    localparam int RATE_BITS   = 16;
    localparam int FARE_SHIFT  = 8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_COORD_BITS  = 24;

    // Fare rate after reset: 5.0 in unsigned Q8.8
    localparam logic [RATE_BITS-1:0] FARE_RATE_RESET = 16'd1280;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t ST_ADDED   = 2'd0;
    localparam status_t ST_MATCHED = 2'd1;
    localparam status_t ST_NONE    = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_MATCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_CMP,
        S_ROOT,
        S_FARE,
        S_FARE2,
        S_EMIT
    } state_t;

    // Handshake between the sequencer and the root unit
    typedef struct packed {
        logic start;
    } root_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

`default_nettype wire

### design/nam_pos_mem.sv
`default_nettype none

module nam_pos_mem
    import nam_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    parameter int WIDTH = 2 * DEF_COORD_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Store a position on add
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### design/nam_isqrt.sv
`default_nettype none

module nam_isqrt
    import nam_pkg::*;
#(
    parameter int SQ_W   = 2 * DEF_COORD_BITS + 1,
    parameter int ROOT_W = DEF_COORD_BITS + 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire root_ctrl_t        ctrl,
    input  wire logic [SQ_W-1:0]   radicand,
    output root_stat_t             stat,
    output logic      [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W + 1);
    localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (2 * (ROOT_W - 1));

    logic [SQ_W-1:0]   n_reg;
    logic [SQ_W-1:0]   root_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SQ_W:0]     trial;
    logic              fits;

    // One result bit per cycle: try root + bit against the remainder
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, n_reg} >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ROOT_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, partial root and trial bit
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            n_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= BIT_START;
        end else if (busy_reg) begin
            if (fits) begin
                n_reg    <= n_reg - trial[SQ_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

### design/nearest_available_match.sv
`default_nettype none

// Nearest available match. An add word (tuser 0) stores its position in the next
// free slot and returns its index through the emit state and the output register; a
// full table returns status 3. A match word (tuser 1) walks the stored slots one at a
// time through a single memory read port: an unavailable slot takes only the read state,
// an available slot also the difference, two passes through the one shared multiplier
// for the squares, and the sum and compare. The winner's squared distance then goes
// through a bit-serial square root and the same multiplier for the fare; with no
// available slot the result is status 2. The input is ready again as soon as the result
// is loaded and is not ready while a word is at work; the finished result waits in an
// output register, so the next word can be taken while it is still pending. fare_rate
// (Q8.8) is to be written through the cfg channel only while the block is idle; the
// block itself does not enforce this. It resets to 5.0.
module nearest_available_match
    import nam_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    // Input stream
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // tdata: x_coord, y_coord (from bit 0 up), zero padded to whole bytes
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    // tuser: action
    input  wire logic                                      s_tuser,
    // Result stream
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // tdata: slot_index, distance, fare (from bit 0 up)
    output logic [INDEX_BITS+DIST_BITS+FARE_BITS-1:0]      m_tdata,
    // tuser: status
    output logic [STATUS_BITS-1:0]                         m_tuser,
    // Fare rate register write
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [RATE_BITS-1:0]                      cfg_data
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int C       = COORD_BITS;
    localparam int SQ_W    = 2 * C + 1;
    localparam int ROOT_W  = C + 1;
    localparam int MUL_W   = (ROOT_W > RATE_BITS) ? ROOT_W : RATE_BITS;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int OUT_W   = INDEX_BITS + DIST_BITS + FARE_BITS;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [MAX_ENTRIES-1:0] avail_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SQ_W-1:0]      best_sq_reg;
    logic [C-1:0]         req_x_reg, req_y_reg;
    logic [C-1:0]         dx_reg, dy_reg;
    logic [2*C-1:0]       acc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ROOT_W-1:0]    dist_reg;
    logic [RATE_BITS-1:0] fare_rate_reg;

    // Result waiting for the output register
    status_t              res_status_reg;
    logic [INDEX_BITS-1:0] res_index_reg;
    logic [DIST_BITS-1:0] res_dist_reg;
    logic [FARE_BITS-1:0] res_fare_reg;

    logic                 out_valid_reg;
    status_t              out_user_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic                 in_take;
    logic                 is_add;
    logic                 table_full;
    logic                 scan_end;
    logic                 slot_avail;
    logic                 out_free;
    logic [C-1:0]         in_x, in_y;
    logic [2*C-1:0]       rd_data;
    logic [C-1:0]         pos_x, pos_y;
    logic [C:0]           diff_x, diff_y;
    logic [SQ_W-1:0]      sq_sum;
    logic [MUL_W-1:0]     mul_a, mul_b;
    root_ctrl_t           root_ctrl;
    root_stat_t           root_stat;
    logic [ROOT_W-1:0]    root_val;

    assign in_x       = s_tdata[C-1:0];
    assign in_y       = s_tdata[2*C-1:C];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_take    = s_tvalid && s_tready;
    assign is_add     = (s_tuser == ACT_ADD);
    assign table_full = (cnt_reg == CNT_W'(MAX_ENTRIES));
    assign scan_end   = (idx_reg == cnt_reg);
    assign slot_avail = avail_reg[idx_reg[IDX_W-1:0]];
    assign out_free   = !out_valid_reg || m_tready;
    assign cfg_ready  = 1'b1;

    // Position store
    nam_pos_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (2 * C)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (in_take && is_add && !table_full),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data ({in_y, in_x}),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Square root of the best squared distance
    assign root_ctrl.start = (state_reg == S_READ) && scan_end && found_reg;

    nam_isqrt #(
        .SQ_W   (SQ_W),
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (root_ctrl),
        .radicand (best_sq_reg),
        .stat     (root_stat),
        .root     (root_val)
    );

    // Absolute coordinate differences, sign extended by one bit
    assign pos_x  = rd_data[C-1:0];
    assign pos_y  = rd_data[2*C-1:C];
    assign diff_x = {req_x_reg[C-1], req_x_reg} - {pos_x[C-1], pos_x};
    assign diff_y = {req_y_reg[C-1], req_y_reg} - {pos_y[C-1], pos_y};
    assign sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg[2*C-1:0]};

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX: begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_SQY: begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_FARE: begin
                mul_a = MUL_W'(dist_reg);
                mul_b = MUL_W'(fare_rate_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    state_next = is_add ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                if (scan_end) begin
                    state_next = found_reg ? S_ROOT : S_EMIT;
                end else if (slot_avail) begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_CMP;
            S_CMP:   state_next = S_READ;
            S_ROOT: begin
                if (root_stat.done) begin
                    state_next = S_FARE;
                end
            end
            S_FARE:  state_next = S_FARE2;
            S_FARE2: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Table control: fill count, availability, scan position, best so far
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            avail_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (in_take && is_add && !table_full) begin
                cnt_reg <= cnt_reg + 1'b1;
                avail_reg[cnt_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (in_take && !is_add) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (state_reg == S_READ && !scan_end && !slot_avail) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == S_CMP) begin
                idx_reg <= idx_reg + 1'b1;
                if (!found_reg || sq_sum < best_sq_reg) begin
                    found_reg <= 1'b1;
                end
            end
            // Take the winner out of service
            if (state_reg == S_FARE2) begin
                avail_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            req_x_reg <= in_x;
            req_y_reg <= in_y;
            if (is_add) begin
                res_status_reg <= table_full ? ST_FULL : ST_ADDED;
                res_index_reg  <= table_full ? '0 : INDEX_BITS'(cnt_reg);
                res_dist_reg   <= '0;
                res_fare_reg   <= '0;
            end
        end
        if (state_reg == S_READ && scan_end && !found_reg) begin
            res_status_reg <= ST_NONE;
            res_index_reg  <= '0;
            res_dist_reg   <= '0;
            res_fare_reg   <= '0;
        end
        if (state_reg == S_DIFF) begin
            dx_reg <= diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
            dy_reg <= diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
        end
        if (state_reg == S_SQY) begin
            acc_reg <= prod_reg[2*C-1:0];
        end
        if (state_reg == S_CMP && (!found_reg || sq_sum < best_sq_reg)) begin
            best_sq_reg  <= sq_sum;
            best_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (state_reg == S_ROOT && root_stat.done) begin
            dist_reg <= root_val;
        end
        if (state_reg == S_FARE2) begin
            res_status_reg <= ST_MATCHED;
            res_index_reg  <= INDEX_BITS'(best_idx_reg);
            res_dist_reg   <= DIST_BITS'(dist_reg);
            res_fare_reg   <= FARE_BITS'(prod_reg >> FARE_SHIFT);
        end
    end

    // Fare rate register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fare_rate_reg <= FARE_RATE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fare_rate_reg <= cfg_data;
        end
    end

    // Output register: load the finished word, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            out_user_reg <= res_status_reg;
            out_data_reg <= {res_fare_reg, res_dist_reg, res_index_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

    // Fill count never passes the table size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond table size");

    // The scan never runs past the filled slots
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ || state_reg == S_CMP) |-> idx_reg <= cnt_reg)
        else $error("scan position beyond fill count");

    // The best candidate is still available while the scan runs
    a_best_avail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && found_reg) |-> avail_reg[best_idx_reg])
        else $error("best candidate not available");

    // The root unit only runs and finishes while the sequencer waits for it
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (root_stat.busy || root_stat.done) |-> state_reg == S_ROOT)
        else $error("root unit active outside its wait state");

    // The fill count moves only on an accepted add
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && cnt_reg != $past(cnt_reg)) |->
            $past(s_tvalid && s_tready && s_tuser == ACT_ADD))
        else $error("fill count changed without an add");

endmodule

`default_nettype wire
